### src/rmsp_pkg.sv
// Types and constants shared by the routing message segment parser modules.
package rmsp_pkg;

  typedef enum logic [2:0] {
    PH_HEADER,
    PH_CNT_LO,
    PH_CNT_HI,
    PH_START_LO,
    PH_START_HI,
    PH_ENT_LO,
    PH_ENT_HI,
    PH_IDLE
  } phase_t;

  localparam logic [15:0] ENTRY_UNREACHABLE = 16'h7fff;
  localparam logic [7:0]  TYPE_MASK         = 8'h0e;
  localparam logic [2:0]  TYPE_NODE         = 3'd3;
  localparam logic [2:0]  TYPE_AREA         = 3'd4;

  localparam logic [1:0]  LEVEL_NONE        = 2'd0;
  localparam logic [1:0]  LEVEL_NODE        = 2'd1;
  localparam logic [1:0]  LEVEL_AREA        = 2'd2;

  localparam logic        KIND_ENTRY        = 1'b0;
  localparam logic        KIND_SUMMARY      = 1'b1;

  localparam int          OUT_TDATA_BITS    = 72;
  localparam int          IN_TDATA_BITS     = 24;

  typedef struct packed {
    logic [15:0] message_length;
    logic [7:0]  data_byte;
    logic        first_byte;
    logic        last_byte;
  } in_item_t;

  typedef struct packed {
    logic        result_kind;
    logic [1:0]  routing_level;
    logic [15:0] source_address;
    logic [15:0] target_id;
    logic [5:0]  hop_count;
    logic [8:0]  path_cost;
    logic [15:0] received_checksum;
  } result_t;

  typedef struct packed {
    logic       space;
    logic [1:0] count;
  } out_status_t;

endpackage

### src/rmsp_in_stage.sv
// Input register stage: holds one accepted request until the parser takes it.
module rmsp_in_stage (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [23:0]       s_axis_tdata,  // data_byte[7:0], message_length[23:8]
  input  logic              s_axis_tlast,
  input  logic              s_axis_tuser,  // first_byte
  input  logic              take,
  output logic              item_valid,
  output rmsp_pkg::in_item_t item
);
  import rmsp_pkg::*;

  assign s_axis_tready = !item_valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (s_axis_tvalid && s_axis_tready) begin
      item_valid <= 1'b1;
    end else if (take) begin
      item_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      item.data_byte      <= s_axis_tdata[7:0];
      item.message_length <= s_axis_tdata[23:8];
      item.first_byte     <= s_axis_tuser;
      item.last_byte      <= s_axis_tlast;
    end
  end

endmodule

### src/rmsp_parser.sv
// Parse state and per-byte update; produces at most one result per byte.
module rmsp_parser #(
  parameter int POSITION_BITS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               take,
  input  rmsp_pkg::in_item_t item,
  output logic               push,
  output rmsp_pkg::result_t  result
);
  import rmsp_pkg::*;

  localparam logic [POSITION_BITS-1:0] POS_MAX = '1;

  logic [POSITION_BITS-1:0] pos, pos_c, pos_next;
  phase_t                   phase, phase_c, phase_next;
  logic [15:0]              len, len_c;
  logic [1:0]               level, level_c, level_next;
  logic [15:0]              sender, sender_c, sender_next;
  logic [15:0]              remaining, remaining_c, remaining_next;
  logic [15:0]              cur_id, cur_id_c, cur_id_next;
  logic [7:0]               hold, hold_c, hold_next;
  logic [15:0]              cksum, cksum_c, cksum_next;
  logic [16:0]              p_ext;
  logic [16:0]              len_ext;
  logic                     in_body;
  logic                     seg_room;
  logic [15:0]              entry;
  logic [15:0]              remaining_dec;
  logic [2:0]               msg_type;
  logic                     emit;

  always_comb begin
    pos_c       = pos;
    phase_c     = phase;
    len_c       = len;
    level_c     = level;
    sender_c    = sender;
    remaining_c = remaining;
    cur_id_c    = cur_id;
    hold_c      = hold;
    cksum_c     = cksum;
    if (item.first_byte) begin
      pos_c       = '0;
      phase_c     = PH_HEADER;
      len_c       = item.message_length;
      level_c     = LEVEL_NONE;
      sender_c    = '0;
      remaining_c = '0;
      cur_id_c    = '0;
      hold_c      = '0;
      cksum_c     = '0;
    end

    cksum_next     = {item.data_byte, cksum_c[15:8]};
    phase_next     = phase_c;
    level_next     = level_c;
    sender_next    = sender_c;
    remaining_next = remaining_c;
    cur_id_next    = cur_id_c;
    hold_next      = hold_c;
    emit           = 1'b0;

    p_ext         = 17'(pos_c);
    len_ext       = {1'b0, len_c};
    in_body       = (p_ext + 17'd2) < len_ext;
    seg_room      = (p_ext + 17'd4) < len_ext;
    entry         = {item.data_byte, hold_c};
    remaining_dec = remaining_c - 16'd1;
    msg_type      = 3'((item.data_byte & TYPE_MASK) >> 1);

    unique case (phase_c)
      PH_HEADER: begin
        if (p_ext == 17'd0) begin
          level_next = (msg_type == TYPE_NODE) ? LEVEL_NODE :
                       (msg_type == TYPE_AREA) ? LEVEL_AREA : LEVEL_NONE;
        end else if (p_ext == 17'd1) begin
          sender_next = {sender_c[15:8], item.data_byte};
        end else if (p_ext == 17'd2) begin
          sender_next = {item.data_byte, sender_c[7:0]};
        end
        if (p_ext >= 17'd3) phase_next = PH_CNT_LO;
      end
      PH_CNT_LO: begin
        if (in_body) begin
          if (seg_room) begin
            hold_next  = item.data_byte;
            phase_next = PH_CNT_HI;
          end else begin
            phase_next = PH_IDLE;
          end
        end
      end
      PH_CNT_HI: begin
        if (in_body) begin
          remaining_next = entry;
          phase_next     = PH_START_LO;
        end
      end
      PH_START_LO: begin
        if (in_body) begin
          hold_next  = item.data_byte;
          phase_next = PH_START_HI;
        end
      end
      PH_START_HI: begin
        if (in_body) begin
          cur_id_next = entry;
          phase_next  = (remaining_c != '0) ? PH_ENT_LO : PH_CNT_LO;
        end
      end
      PH_ENT_LO: begin
        if (in_body) begin
          hold_next  = item.data_byte;
          phase_next = PH_ENT_HI;
        end
      end
      PH_ENT_HI: begin
        if (in_body) begin
          emit           = (entry != ENTRY_UNREACHABLE) && (level_c != LEVEL_NONE);
          cur_id_next    = cur_id_c + 16'd1;
          remaining_next = remaining_dec;
          phase_next     = (remaining_dec != '0) ? PH_ENT_LO : PH_CNT_LO;
        end
      end
      PH_IDLE: begin
      end
    endcase

    pos_next = (pos_c == POS_MAX) ? pos_c : pos_c + POSITION_BITS'(1);

    push                     = take && (item.last_byte || emit);
    result.routing_level     = level_next;
    result.source_address    = sender_next;
    result.received_checksum = cksum_next;
    if (item.last_byte) begin
      result.result_kind = KIND_SUMMARY;
      result.target_id   = '0;
      result.hop_count   = '0;
      result.path_cost   = '0;
    end else begin
      result.result_kind = KIND_ENTRY;
      result.target_id   = cur_id_c;
      result.hop_count   = entry[14:9];
      result.path_cost   = entry[8:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos       <= '0;
      phase     <= PH_HEADER;
      len       <= '0;
      level     <= LEVEL_NONE;
      sender    <= '0;
      remaining <= '0;
      cur_id    <= '0;
      hold      <= '0;
      cksum     <= '0;
    end else if (take) begin
      pos       <= pos_next;
      phase     <= phase_next;
      len       <= len_c;
      level     <= level_next;
      sender    <= sender_next;
      remaining <= remaining_next;
      cur_id    <= cur_id_next;
      hold      <= hold_next;
      cksum     <= cksum_next;
    end
  end

endmodule

### src/rmsp_out_buf.sv
// Two-entry result queue that decouples the parser from the output stream.
module rmsp_out_buf (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  rmsp_pkg::result_t     result,
  input  logic                  pop,
  output logic                  out_valid,
  output rmsp_pkg::result_t     out_result,
  output rmsp_pkg::out_status_t status
);
  import rmsp_pkg::*;

  result_t    mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign out_valid    = count != 2'd0;
  assign out_result   = mem[rd_ptr];
  assign status.count = count;
  assign status.space = count != 2'd2;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop) rd_ptr <= !rd_ptr;
      count <= count + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= result;
  end

endmodule

### src/routing_message_segment_parser.sv
// Top level of the routing message segment parser.
// Takes one message byte per cycle, with no gaps required, while the output queue
// has room. Each request passes an input register, is parsed combinationally
// against the running message state, and its result, if any, enters a two-entry
// output queue, from which it is offered on the master side until it is accepted.
// The input stalls only while the queue holds two results. Byte 0 sets the level,
// bytes 1-2 the source address; segments follow from byte 4 and end before the
// trailing checksum word. Reachable entries and the end-of-message summary leave
// in order.
module routing_message_segment_parser #(
  parameter int POSITION_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,  // data_byte[7:0], message_length[23:8]
  input  logic        s_axis_tlast,  // last_byte
  input  logic        s_axis_tuser,  // first_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // routing_level[1:0], source_address[17:2], target_id[33:18], hop_count[39:34],
  // path_cost[48:40], received_checksum[64:49], zero fill[71:65]
  output logic [71:0] m_axis_tdata,
  output logic        m_axis_tuser   // result_kind
);
  import rmsp_pkg::*;

  in_item_t    item;
  logic        item_valid;
  logic        take;
  logic        push;
  logic        pop;
  result_t     result;
  result_t     out_result;
  out_status_t ob_status;

  assign take = item_valid && ob_status.space;
  assign pop  = m_axis_tvalid && m_axis_tready;

  rmsp_in_stage u_in_stage (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .s_axis_tuser  (s_axis_tuser),
    .take          (take),
    .item_valid    (item_valid),
    .item          (item)
  );

  rmsp_parser #(
    .POSITION_BITS (POSITION_BITS)
  ) u_parser (
    .clk    (clk),
    .rst    (rst),
    .take   (take),
    .item   (item),
    .push   (push),
    .result (result)
  );

  rmsp_out_buf u_out_buf (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .result     (result),
    .pop        (pop),
    .out_valid  (m_axis_tvalid),
    .out_result (out_result),
    .status     (ob_status)
  );

  assign m_axis_tuser = out_result.result_kind;
  assign m_axis_tdata = {7'b0, out_result.received_checksum, out_result.path_cost,
                         out_result.hop_count, out_result.target_id,
                         out_result.source_address, out_result.routing_level};

  assert property (@(posedge clk) disable iff (rst) ob_status.count <= 2'd2)
    else $error("result queue overflow");

  assert property (@(posedge clk) disable iff (rst)
    (push && result.result_kind == KIND_SUMMARY) |-> item.last_byte)
    else $error("summary without last byte");

  assert property (@(posedge clk) disable iff (rst) !item_valid |-> s_axis_tready)
    else $error("input stalled while input register empty");

  assert property (@(posedge clk) disable iff (rst)
    (push && !pop && ob_status.count == 2'd1) |=> ob_status.count == 2'd2)
    else $error("result lost in queue");

endmodule

### tb/rmsp_checker.sv
// Checker for the routing message segment parser: predicts results and compares.
`timescale 1ns / 100ps

module rmsp_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,  // data_byte[7:0], message_length[23:8]
  input  logic        s_axis_tlast,  // last_byte
  input  logic        s_axis_tuser,  // first_byte
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // routing_level[1:0], source_address[17:2], target_id[33:18], hop_count[39:34],
  // path_cost[48:40], received_checksum[64:49], zero fill[71:65]
  input  logic [71:0] m_axis_tdata,
  input  logic        m_axis_tuser,  // result_kind
  output int          errors,
  output int          pending,
  output int          requests,
  output int          entries,
  output int          summaries
);
  import rmsp_pkg::*;

  localparam int MAX_REPORTS = 40;

  logic [15:0] pos;
  phase_t      phase;
  logic [15:0] msg_len;
  logic [1:0]  level;
  logic [15:0] src_addr;
  logic [15:0] remaining;
  logic [15:0] next_id;
  logic [7:0]  held_byte;
  logic [15:0] csum_word;

  result_t     expected_results[$];

  function automatic void clear_parser();
    pos       = '0;
    phase     = PH_HEADER;
    msg_len   = '0;
    level     = LEVEL_NONE;
    src_addr  = '0;
    remaining = '0;
    next_id   = '0;
    held_byte = '0;
    csum_word = '0;
  endfunction

  task automatic advance_parser(input logic [7:0] b, input logic first, input logic last,
                                input logic [15:0] len);
    logic [2:0]  mtype;
    logic [15:0] entry;
    logic [15:0] eid;
    logic        emit;
    result_t     res;
    int          p;
    emit  = 1'b0;
    entry = '0;
    eid   = '0;
    if (first) begin
      clear_parser();
      msg_len = len;
    end
    p = int'(pos);
    csum_word = {b, csum_word[15:8]};
    if (phase == PH_HEADER) begin
      if (p == 0) begin
        mtype = 3'((b & TYPE_MASK) >> 1);
        level = (mtype == TYPE_NODE) ? LEVEL_NODE :
                (mtype == TYPE_AREA) ? LEVEL_AREA : LEVEL_NONE;
      end else if (p == 1) begin
        src_addr[7:0] = b;
      end else if (p == 2) begin
        src_addr[15:8] = b;
      end
      if (p >= 3) phase = PH_CNT_LO;
    end else if (phase != PH_IDLE && p + 2 < int'(msg_len)) begin
      case (phase)
        PH_CNT_LO: begin
          if (p + 4 < int'(msg_len)) begin
            held_byte = b;
            phase = PH_CNT_HI;
          end else begin
            phase = PH_IDLE;
          end
        end
        PH_CNT_HI: begin
          remaining = {b, held_byte};
          phase = PH_START_LO;
        end
        PH_START_LO: begin
          held_byte = b;
          phase = PH_START_HI;
        end
        PH_START_HI: begin
          next_id = {b, held_byte};
          phase = (remaining != 0) ? PH_ENT_LO : PH_CNT_LO;
        end
        PH_ENT_LO: begin
          held_byte = b;
          phase = PH_ENT_HI;
        end
        default: begin
          entry = {b, held_byte};
          eid = next_id;
          if (entry != ENTRY_UNREACHABLE && level != LEVEL_NONE) emit = 1'b1;
          next_id = next_id + 16'd1;
          remaining = remaining - 16'd1;
          phase = (remaining != 0) ? PH_ENT_LO : PH_CNT_LO;
        end
      endcase
    end
    if (pos != 16'hffff) pos = pos + 16'd1;
    if (last) begin
      res = '{KIND_SUMMARY, level, src_addr, 16'h0, 6'h0, 9'h0, csum_word};
      expected_results.push_back(res);
    end else if (emit) begin
      res = '{KIND_ENTRY, level, src_addr, eid, entry[14:9], entry[8:0], csum_word};
      expected_results.push_back(res);
    end
  endtask

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      if (errors < MAX_REPORTS) $error("%s expected 0x%0h got 0x%0h", name, want, got);
      errors++;
    end
  endfunction

  task automatic compare_result();
    result_t got;
    result_t want;
    got.result_kind       = m_axis_tuser;
    got.routing_level     = m_axis_tdata[1:0];
    got.source_address    = m_axis_tdata[17:2];
    got.target_id         = m_axis_tdata[33:18];
    got.hop_count         = m_axis_tdata[39:34];
    got.path_cost         = m_axis_tdata[48:40];
    got.received_checksum = m_axis_tdata[64:49];
    if (got.result_kind == KIND_SUMMARY) summaries++;
    else entries++;
    if (expected_results.size() == 0) begin
      if (errors < MAX_REPORTS) $error("unexpected result 0x%0h kind %0b", m_axis_tdata,
                                       m_axis_tuser);
      errors++;
    end else begin
      want = expected_results.pop_front();
      check_field("result_kind", want.result_kind, got.result_kind);
      check_field("routing_level", want.routing_level, got.routing_level);
      check_field("source_address", want.source_address, got.source_address);
      check_field("target_id", want.target_id, got.target_id);
      check_field("hop_count", want.hop_count, got.hop_count);
      check_field("path_cost", want.path_cost, got.path_cost);
      check_field("received_checksum", want.received_checksum, got.received_checksum);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      clear_parser();
      expected_results.delete();
      errors    = 0;
      pending   = 0;
      requests  = 0;
      entries   = 0;
      summaries = 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        requests++;
        advance_parser(s_axis_tdata[7:0], s_axis_tuser, s_axis_tlast, s_axis_tdata[23:8]);
      end
      if (m_axis_tvalid && m_axis_tready) compare_result();
      pending = expected_results.size();
    end
  end

endmodule

### tb/tb.sv
// Testbench top for the routing message segment parser: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module tb;
  import rmsp_pkg::*;

  localparam int LIMIT       = 1_000_000;
  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN       = 20;
  localparam int RANDOM_BYTES = 870;

  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata;
  logic        s_axis_tlast;
  logic        s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [71:0] m_axis_tdata;
  logic        m_axis_tuser;

  int          chk_errors;
  int          chk_pending;
  int          chk_requests;
  int          chk_entries;
  int          chk_summaries;

  logic [7:0]  msg_bytes[$];
  bit          quiet;
  bit          hold_req;
  int          random_bytes;
  int          cycles;

  routing_message_segment_parser i_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  rmsp_checker i_check (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .errors        (chk_errors),
    .pending       (chk_pending),
    .requests      (chk_requests),
    .entries       (chk_entries),
    .summaries     (chk_summaries)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic int pick_gap();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic first, input logic last,
                           input logic [15:0] len);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {len, b};
    s_axis_tuser  <= first;
    s_axis_tlast  <= last;
    do @(posedge clk); while (!s_axis_tready);
  endtask

  task automatic send_message(input logic [15:0] len, input int first_at, input int last_at);
    for (int i = 0; i < msg_bytes.size(); i++)
      send_byte(msg_bytes[i], i == first_at, i == last_at, len);
  endtask

  task automatic build_routing(input logic [2:0] mtype, input int nseg, input int max_count);
    logic [7:0]  r;
    logic [15:0] start;
    logic [15:0] ent;
    logic [15:0] cnt;
    msg_bytes.delete();
    r = 8'($urandom);
    msg_bytes.push_back({r[7:4], mtype, r[0]});
    repeat (3) msg_bytes.push_back(8'($urandom));
    for (int s = 0; s < nseg; s++) begin
      cnt = ($urandom_range(0, 9) == 0) ? 16'd0 : 16'($urandom_range(1, max_count));
      start = ($urandom_range(0, 7) == 0) ? 16'hfffd : 16'($urandom);
      msg_bytes.push_back(cnt[7:0]);
      msg_bytes.push_back(cnt[15:8]);
      msg_bytes.push_back(start[7:0]);
      msg_bytes.push_back(start[15:8]);
      for (int e = 0; e < int'(cnt); e++) begin
        ent = ($urandom_range(0, 6) == 0) ? ENTRY_UNREACHABLE : 16'($urandom);
        msg_bytes.push_back(ent[7:0]);
        msg_bytes.push_back(ent[15:8]);
      end
    end
    repeat (2) msg_bytes.push_back(8'($urandom));
  endtask

  function automatic logic [2:0] pick_type();
    int r;
    r = $urandom_range(0, 9);
    if (r < 4) return TYPE_NODE;
    if (r < 8) return TYPE_AREA;
    return 3'($urandom);
  endfunction

  // receiver side: random stalls, plus one long hold-off on request
  initial begin
    int stall;
    m_axis_tready = 1'b0;
    stall = 0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (stall > 0) begin
        m_axis_tready <= 1'b0;
        stall--;
      end else begin
        m_axis_tready <= 1'b1;
        stall = pick_gap();
      end
    end
  end

  initial begin
    for (cycles = 0; cycles < LIMIT; cycles++) @(posedge clk);
    $display("routing_message_segment_parser test failed");
    $finish;
  end

  initial begin
    int n;
    int kind;
    int last_at;
    logic [15:0] len;
    rst           = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tlast  = 1'b0;
    s_axis_tuser  = 1'b0;
    quiet         = 1'b0;
    hold_req      = 1'b0;
    random_bytes  = 0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // bytes with no start mark, parsed from reset with zero length
    msg_bytes = '{8'h06, 8'hff, 8'h00};
    send_message(16'h1234, -1, 2);
    // level one: id wraps from 0xffff, entry values at both extremes
    msg_bytes = '{8'h06, 8'hff, 8'hff, 8'h00, 8'h02, 8'h00, 8'hff, 8'hff,
                  8'h00, 8'h00, 8'hff, 8'hff, 8'haa, 8'h55};
    send_message(16'd14, 0, 13);
    // level two: unreachable entry in a segment that is cut off by the checksum
    msg_bytes = '{8'h08, 8'h34, 8'h12, 8'h00, 8'h05, 8'h00, 8'h10, 8'h00,
                  8'hff, 8'h7f, 8'h01, 8'h02};
    send_message(16'd12, 0, 11);

    // hold the receiver off while a long message keeps coming
    quiet = 1'b1;
    build_routing(TYPE_NODE, 2, 20);
    hold_req = 1'b1;
    send_message(16'(msg_bytes.size()), 0, msg_bytes.size() - 1);

    while (random_bytes < RANDOM_BYTES) begin
      quiet = ($urandom_range(0, 3) == 0);
      kind = $urandom_range(0, 9);
      build_routing(pick_type(), $urandom_range(1, 3), 6);
      n = msg_bytes.size();
      if (kind < 7) begin
        send_message(16'(n), 0, n - 1);
      end else if (kind == 7) begin
        len = $urandom_range(0, 1) ? 16'($urandom_range(0, n + 8)) : 16'($urandom);
        send_message(len, 0, n - 1);
      end else if (kind == 8) begin
        last_at = $urandom_range(0, 1) ? $urandom_range(4, n - 1) : -1;
        send_message(16'(n), 0, last_at);
      end else begin
        n = $urandom_range(1, 12);
        for (int i = 0; i < n; i++)
          send_byte(8'($urandom), $urandom_range(0, 7) == 0, $urandom_range(0, 3) == 0,
                    16'($urandom));
      end
      random_bytes += n;
    end
    s_axis_tvalid <= 1'b0;
    quiet = 1'b0;

    repeat (DRAIN) @(posedge clk);
    while (chk_pending != 0) @(posedge clk);

    $display("run covered %0d requests, %0d reachable entries, %0d message summaries",
             chk_requests, chk_entries, chk_summaries);
    $display("with well-formed, broken and noise messages and a long receiver hold-off");
    if (chk_errors == 0 && chk_pending == 0) begin
      $display("routing_message_segment_parser test passed");
    end else begin
      $display("routing_message_segment_parser test failed");
    end
    $finish;
  end

endmodule

### filelist.f
src/rmsp_pkg.sv
src/rmsp_in_stage.sv
src/rmsp_parser.sv
src/rmsp_out_buf.sv
src/routing_message_segment_parser.sv
tb/rmsp_checker.sv
tb/tb.sv
